/* rtl/stfp_pkg.sv */
// ----------------------------------------------------------------------------
// Suffix-tagged field parser package
// Shared constants, register indexes and conversion phase codes.
// ----------------------------------------------------------------------------
package stfp_pkg;

    // Default field buffer size in bytes; capacity is one less than this.
    localparam int BUFFER_BYTES_DEFAULT = 8;

    // Bytes of text that a result carries at most.
    localparam int TEXT_MAX_BYTES = 7;

    // Register reset values.
    localparam logic [7:0] SPEED_TAG_RESET   = 8'd86;
    localparam logic [7:0] RPM_TAG_RESET     = 8'd83;
    localparam logic [7:0] GEAR_TAG_RESET    = 8'd69;
    localparam logic [7:0] SPEED_LIMIT_RESET = 8'd100;

    // Conversion limits.
    localparam logic [23:0] MAG_MAX       = 24'hFF_FFFF;
    localparam logic [23:0] MAG_MUL_LIMIT = 24'd1677720;   // (MAG_MAX - 9) / 10
    localparam logic [20:0] NEG_FLOOR_MAG = 21'h10_0000;   // magnitude of -2^20

    // ASCII codes used by the conversion.
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // Field kinds reported on a result.
    localparam logic [1:0] KIND_SPEED = 2'd0;
    localparam logic [1:0] KIND_RPM   = 2'd1;
    localparam logic [1:0] KIND_GEAR  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPEED_TAG   = 2'd0,
        CFG_RPM_TAG     = 2'd1,
        CFG_GEAR_TAG    = 2'd2,
        CFG_SPEED_LIMIT = 2'd3
    } cfg_reg_t;

    // Number conversion phases.
    typedef enum logic [1:0] {
        PHASE_SPACE  = 2'd0,
        PHASE_DIGITS = 2'd1,
        PHASE_DONE   = 2'd2
    } phase_t;

endpackage

/* rtl/suffix_tagged_field_parser.sv */
// ----------------------------------------------------------------------------
// Suffix-tagged field parser
// Buffers received bytes until a tag byte closes the field as speed, rpm or
// gear, and converts speed text to a clamped signed value as bytes arrive.
// ----------------------------------------------------------------------------
// A result appears on the output register in the cycle after its tag byte is
// accepted. The block takes one byte per cycle while the input is not stalled;
// the per-byte multiply by ten is combinational. The input stalls only
// while a result waits in the output register and the output is stalled.
// Reset clears the field buffer and conversion state and loads the tag
// registers with V, S, E and the speed limit with 100.
module suffix_tagged_field_parser #(
    parameter int BUFFER_BYTES = stfp_pkg::BUFFER_BYTES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [stfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data,
    // Input byte channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       received_byte,
    // Result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       field_kind,
    output logic [55:0]                      field_text,
    output logic [2:0]                       field_length,
    output logic signed [20:0]               speed_value
);

    import stfp_pkg::*;

    localparam int FIELD_CAP  = BUFFER_BYTES - 1;
    localparam int TEXT_BYTES = (FIELD_CAP < TEXT_MAX_BYTES) ? FIELD_CAP : TEXT_MAX_BYTES;
    localparam int CNT_W      = $clog2(BUFFER_BYTES);

    // Configuration registers
    logic [7:0] speed_tag_reg;
    logic [7:0] rpm_tag_reg;
    logic [7:0] gear_tag_reg;
    logic [7:0] speed_limit_reg;

    // Field and conversion state
    logic [7:0]       buffer_reg [TEXT_BYTES];
    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic             negative_reg;
    logic             negative_next;
    logic [23:0]      magnitude_reg;
    logic [23:0]      magnitude_next;

    // Result register
    logic               out_valid_reg;
    logic [1:0]         field_kind_reg;
    logic [55:0]        field_text_reg;
    logic [2:0]         field_length_reg;
    logic signed [20:0] speed_value_reg;

    // Combinational signals
    logic               in_accept;
    logic               out_accept;
    logic               is_tag;
    logic [1:0]         kind_sel;
    logic               has_room;
    logic               store_byte;
    logic               clear_field;
    logic               is_digit;
    logic               is_space;
    logic [27:0]        mag_times_ten;
    logic [27:0]        mag_sum;
    logic [23:0]        mag_step;
    logic [55:0]        text_now;
    logic [4:0]         count_wide;
    logic [2:0]         length_now;
    logic [20:0]        mag_floor;
    logic signed [20:0] speed_now;

    // Handshakes
    assign cfg_ready  = 1'b1;
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_tag_reg   <= SPEED_TAG_RESET;
            rpm_tag_reg     <= RPM_TAG_RESET;
            gear_tag_reg    <= GEAR_TAG_RESET;
            speed_limit_reg <= SPEED_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SPEED_TAG:   speed_tag_reg   <= cfg_data;
                CFG_RPM_TAG:     rpm_tag_reg     <= cfg_data;
                CFG_GEAR_TAG:    gear_tag_reg    <= cfg_data;
                CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Tag match, with speed taking priority over rpm and rpm over gear.
    always_comb
    begin
        is_tag   = 1'b1;
        kind_sel = KIND_SPEED;
        if (received_byte == speed_tag_reg)
        begin
            kind_sel = KIND_SPEED;
        end
        else if (received_byte == rpm_tag_reg)
        begin
            kind_sel = KIND_RPM;
        end
        else if (received_byte == gear_tag_reg)
        begin
            kind_sel = KIND_GEAR;
        end
        else
        begin
            is_tag = 1'b0;
        end
    end

    // A plain byte is stored while there is room; one more clears the field.
    assign has_room    = byte_count_reg < CNT_W'(FIELD_CAP);
    assign store_byte  = in_accept && !is_tag && has_room;
    assign clear_field = in_accept && (is_tag || !has_room);

    // Character classes for the conversion.
    assign is_digit = (received_byte >= CHAR_ZERO) && (received_byte <= CHAR_NINE);
    assign is_space = (received_byte == CHAR_SPACE)
                   || ((received_byte >= CHAR_TAB) && (received_byte <= CHAR_CR));

    // Saturating magnitude * 10 + digit.
    assign mag_times_ten = {magnitude_reg, 3'b000} + {3'b000, magnitude_reg, 1'b0};
    assign mag_sum       = mag_times_ten + 28'(received_byte - CHAR_ZERO);
    assign mag_step      = ((magnitude_reg > MAG_MUL_LIMIT) || (mag_sum > 28'(MAG_MAX)))
                         ? MAG_MAX : mag_sum[23:0];

    // Next state of the conversion and the byte count.
    always_comb
    begin
        byte_count_next = byte_count_reg;
        phase_next      = phase_reg;
        negative_next   = negative_reg;
        magnitude_next  = magnitude_reg;
        if (clear_field)
        begin
            byte_count_next = '0;
            phase_next      = PHASE_SPACE;
            negative_next   = 1'b0;
            magnitude_next  = '0;
        end
        else if (store_byte)
        begin
            byte_count_next = byte_count_reg + CNT_W'(1);
            unique case (phase_reg)
                PHASE_SPACE:
                begin
                    if (is_space)
                    begin
                        phase_next = PHASE_SPACE;
                    end
                    else if ((received_byte == CHAR_PLUS) || (received_byte == CHAR_MINUS))
                    begin
                        negative_next = (received_byte == CHAR_MINUS);
                        phase_next    = PHASE_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        magnitude_next = mag_step;
                        phase_next     = PHASE_DIGITS;
                    end
                    else
                    begin
                        phase_next = PHASE_DONE;
                    end
                end
                PHASE_DIGITS:
                begin
                    if (is_digit)
                    begin
                        magnitude_next = mag_step;
                    end
                    else
                    begin
                        phase_next = PHASE_DONE;
                    end
                end
                PHASE_DONE:
                begin
                    phase_next = PHASE_DONE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Field and conversion state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            phase_reg      <= PHASE_SPACE;
            negative_reg   <= 1'b0;
            magnitude_reg  <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            phase_reg      <= phase_next;
            negative_reg   <= negative_next;
            magnitude_reg  <= magnitude_next;
        end
    end

    // Text bytes; bytes past the seventh are counted but not kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TEXT_BYTES; i++)
            begin
                buffer_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < TEXT_BYTES; i++)
            begin
                if (clear_field)
                begin
                    buffer_reg[i] <= '0;
                end
                else if (store_byte && (byte_count_reg == CNT_W'(i)))
                begin
                    buffer_reg[i] <= received_byte;
                end
            end
        end
    end

    // Result text, with unwritten bytes already zero.
    always_comb
    begin
        text_now = '0;
        for (int i = 0; i < TEXT_BYTES; i++)
        begin
            text_now[8*i +: 8] = buffer_reg[i];
        end
    end

    // Length saturates at seven bytes.
    assign count_wide = 5'(byte_count_reg);
    assign length_now = (count_wide > 5'(TEXT_MAX_BYTES)) ? 3'(TEXT_MAX_BYTES) : count_wide[2:0];

    // Signed speed: negative values floor at -2^20, positive ones clamp to the limit.
    assign mag_floor = (magnitude_reg > 24'(NEG_FLOOR_MAG)) ? NEG_FLOOR_MAG : magnitude_reg[20:0];
    always_comb
    begin
        if (kind_sel != KIND_SPEED)
        begin
            speed_now = '0;
        end
        else if (negative_reg)
        begin
            speed_now = -$signed(mag_floor);
        end
        else if (magnitude_reg > 24'(speed_limit_reg))
        begin
            speed_now = $signed(21'(speed_limit_reg));
        end
        else
        begin
            speed_now = $signed(magnitude_reg[20:0]);
        end
    end

    // Output register: loaded by a tag byte, emptied when the result is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept && is_tag)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_accept && is_tag)
        begin
            field_kind_reg   <= kind_sel;
            field_text_reg   <= text_now;
            field_length_reg <= length_now;
            speed_value_reg  <= speed_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign field_kind   = field_kind_reg;
    assign field_text   = field_text_reg;
    assign field_length = field_length_reg;
    assign speed_value  = speed_value_reg;

    // The byte count never passes the buffer capacity.
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(FIELD_CAP))
        else $error("Byte count exceeds buffer capacity.");

    // An accepted tag byte always leaves a result in the output register.
    a_tag_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && is_tag) |=> out_valid_reg)
        else $error("Accepted tag byte produced no result.");

    // A closed field leaves the buffer empty for the next one.
    a_tag_clears_field: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && is_tag) |=> (byte_count_reg == '0) && (magnitude_reg == '0))
        else $error("Field state not cleared after tag byte.");

    // Only speed results carry a converted value.
    a_speed_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (field_kind_reg != KIND_SPEED)) |-> (speed_value_reg == '0))
        else $error("Non-speed result carries a speed value.");

    // The input is held back only while a result is waiting.
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("Input stalled with an empty output register.");

endmodule
